### src/dhvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dhvd_pkg;

  // Field widths fixed by the interface.
  localparam int MVW    = 16;  // signed millivolt commands
  localparam int BATW   = 15;  // battery millivolts
  localparam int OVLW   = 16;  // overload count and limit
  localparam int DBW    = 12;  // deadband counts
  localparam int OFFW   = 11;  // minimum offset millivolts
  localparam int LOSSW  = 12;  // driver loss millivolts
  localparam int MODEW  = 2;
  localparam int DUTYW  = 12;
  localparam int SPWMW  = 16;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  // Datapath widths of the scaling lanes.
  localparam int MAGW = 16;  // magnitude after the offset, at most 34815
  localparam int DIVW = 15;  // battery minus loss, 1405 to 32767
  localparam int QW   = 15;  // quotient magnitude before saturation

  localparam int unsigned PWM_FULL_DEF = 4095;

  // Battery substitution when the measurement is implausibly low.
  localparam logic [BATW-1:0] BAT_MIN_MV     = BATW'(5500);
  localparam logic [BATW-1:0] BAT_DEFAULT_MV = BATW'(11100);

  // A command whose magnitudes are both below this counts as a stop.
  localparam logic signed [MVW-1:0] STOP_MV = MVW'(10);

  // Register reset values.
  localparam logic [OVLW-1:0]  OVL_LIMIT_RST = OVLW'(500);
  localparam logic [OFFW-1:0]  MIN_OFF_RST   = OFFW'(400);
  localparam logic [LOSSW-1:0] LOSS_RST      = LOSSW'(1000);

  // Register indexes on the configuration port.
  localparam logic [CFG_IW-1:0] REG_LEFT_DB   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_RIGHT_DB  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_OVL_LIMIT = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MIN_OFF   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LOSS      = 3'd4;

  // Bridge pin modes.
  localparam logic [MODEW-1:0] MODE_LOW  = 2'd0;
  localparam logic [MODEW-1:0] MODE_HIGH = 2'd1;
  localparam logic [MODEW-1:0] MODE_FWD  = 2'd2;
  localparam logic [MODEW-1:0] MODE_REV  = 2'd3;

  // What a scaling lane hands back once its division is finished.
  typedef struct packed {
    logic             nz;    // scaled value is nonzero
    logic             neg;   // command sign
    logic [DUTYW-1:0] duty;  // compare value for the driven pin
    logic [SPWMW-1:0] spwm;  // signed count including deadband
  } lane_res_t;

endpackage

`default_nettype wire

### src/dhvd_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dhvd_lane #(
  parameter int unsigned PWM_FULL = dhvd_pkg::PWM_FULL_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic                       take,
  input  wire logic [dhvd_pkg::MAGW-1:0]  mag,
  input  wire logic                       neg,
  input  wire logic [dhvd_pkg::DIVW-1:0]  divisor,
  input  wire logic [dhvd_pkg::DBW-1:0]   deadband,
  output logic                            done,
  output dhvd_pkg::lane_res_t             res
);

  localparam int MAGW  = dhvd_pkg::MAGW;
  localparam int DIVW  = dhvd_pkg::DIVW;
  localparam int QW    = dhvd_pkg::QW;
  localparam int SPWMW = dhvd_pkg::SPWMW;
  localparam int DUTYW = dhvd_pkg::DUTYW;
  localparam int PWW   = $clog2(PWM_FULL + 1);
  localparam int NUMW  = MAGW + PWW;
  localparam int CNTW  = $clog2(MAGW);
  localparam int SUMW  = QW + 1;
  localparam int DCW   = SPWMW + 1;

  localparam logic [CNTW-1:0] MUL_LAST = CNTW'(MAGW - 1);
  localparam logic [CNTW-1:0] DIV_LAST = CNTW'(QW - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]      state;
  logic [CNTW-1:0] cnt;
  logic [NUMW-1:0] acc;
  logic [MAGW-1:0] mag_sh;
  logic [DIVW-1:0] div_r;
  logic            neg_r;
  logic            sat;
  logic [DIVW-1:0] rem;
  logic [QW-1:0]   num_lo;
  logic [QW-1:0]   qsh;

  logic [NUMW-1:0] acc_next;
  logic [NUMW-1:0] hi;
  logic [DIVW:0]   trial;
  logic            ge;

  // Multiply by shift and add, magnitude bits most significant first.
  assign acc_next = {acc[NUMW-2:0], 1'b0} + (mag_sh[MAGW-1] ? NUMW'(PWM_FULL) : '0);
  assign hi       = NUMW'(acc[NUMW-1:QW]);
  // Restoring division, one quotient bit a cycle.
  assign trial    = {rem, num_lo[QW-1]};
  assign ge       = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MUL;
            cnt   <= '0;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          state <= ST_DIV;
          cnt   <= '0;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          acc    <= '0;
          mag_sh <= mag;
          div_r  <= divisor;
          neg_r  <= neg;
          qsh    <= '0;
        end
      end
      ST_MUL: begin
        acc    <= acc_next;
        mag_sh <= {mag_sh[MAGW-2:0], 1'b0};
      end
      ST_CHK: begin
        // The quotient overflows the signed range exactly when the upper
        // numerator part already reaches the divisor.
        sat    <= hi >= NUMW'(div_r);
        rem    <= (hi >= NUMW'(div_r)) ? '0 : DIVW'(hi);
        num_lo <= acc[QW-1:0];
      end
      ST_DIV: begin
        rem    <= ge ? DIVW'(trial - {1'b0, div_r}) : DIVW'(trial);
        num_lo <= {num_lo[QW-2:0], 1'b0};
        qsh    <= {qsh[QW-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  logic [QW-1:0]    q;
  logic [SUMW-1:0]  sum;
  logic [SUMW-1:0]  lim;
  logic [SPWMW-1:0] smag;
  logic [DCW-1:0]   full_ext;

  always_comb begin
    q        = sat ? {QW{1'b1}} : qsh;
    sum      = SUMW'(q) + SUMW'(deadband);
    lim      = neg_r ? SUMW'(32768) : SUMW'(32767);
    full_ext = DCW'(PWM_FULL);
    res.nz   = q != '0;
    res.neg  = neg_r;
    if (!res.nz) begin
      smag = '0;
    end else begin
      smag = SPWMW'((sum > lim) ? lim : sum);
    end
    res.spwm = neg_r ? SPWMW'(~smag + 1'b1) : smag;
    res.duty = ({1'b0, smag} >= full_ext) ? '0 : DUTYW'(full_ext - {1'b0, smag});
  end

  assign done = state == ST_DONE;

endmodule

`default_nettype wire

### src/dual_hbridge_voltage_drive.sv
`timescale 1ns / 1ps
`default_nettype none

// Dual H-bridge voltage drive.
// The command channel (cmd_valid, cmd_stall) carries one item per transfer:
// an operation bit (0 control tick, 1 new voltage command), both voltage
// commands, the battery voltage and the outside overload count. Each item
// yields exactly one result transfer on (res_valid, res_stall) with the pin
// mode, duty, signed PWM and enable flags of both motors.
// Both motors are scaled in parallel lanes by a bit-serial shift-and-add
// multiply, an overflow check and a restoring division. The result is
// registered once both lanes are done and the output register is free; a
// new command is taken once the previous result has moved to that register.
// The finished result waits in the output register, so a stalled receiver
// holds only that result; the next command is accepted meanwhile and its own
// result waits inside the lanes until the output register is taken.
// Configuration writes (cfg_valid, cfg_ready) are always ready and are
// meant only while the block is idle.
// Synchronous reset restores the register defaults, clears the stored
// commands, enables both motors and puts both to sleep.

module dual_hbridge_voltage_drive #(
  parameter int unsigned PWM_FULL = dhvd_pkg::PWM_FULL_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cmd_valid,
  output logic                                    cmd_stall,
  input  wire logic                               operation,
  input  wire logic signed [dhvd_pkg::MVW-1:0]    voltage_left_mv,
  input  wire logic signed [dhvd_pkg::MVW-1:0]    voltage_right_mv,
  input  wire logic [dhvd_pkg::BATW-1:0]          battery_mv,
  input  wire logic [dhvd_pkg::OVLW-1:0]          overload_count,
  output logic                                    res_valid,
  input  wire logic                               res_stall,
  output logic [dhvd_pkg::MODEW-1:0]              left_mode,
  output logic [dhvd_pkg::DUTYW-1:0]              left_duty,
  output logic [dhvd_pkg::MODEW-1:0]              right_mode,
  output logic [dhvd_pkg::DUTYW-1:0]              right_duty,
  output logic signed [dhvd_pkg::SPWMW-1:0]       left_signed_pwm,
  output logic signed [dhvd_pkg::SPWMW-1:0]       right_signed_pwm,
  output logic                                    left_enabled,
  output logic                                    right_enabled,
  output logic                                    overload_trip,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dhvd_pkg::CFG_IW-1:0]        cfg_index,
  input  wire logic [dhvd_pkg::CFG_DW-1:0]        cfg_data
);

  localparam int MVW   = dhvd_pkg::MVW;
  localparam int MAGW  = dhvd_pkg::MAGW;
  localparam int DIVW  = dhvd_pkg::DIVW;
  localparam int BATW  = dhvd_pkg::BATW;
  localparam int MODEW = dhvd_pkg::MODEW;
  localparam int DUTYW = dhvd_pkg::DUTYW;

  // Configuration registers.
  logic [dhvd_pkg::DBW-1:0]   left_db;
  logic [dhvd_pkg::DBW-1:0]   right_db;
  logic [dhvd_pkg::OVLW-1:0]  ovl_limit;
  logic [dhvd_pkg::OFFW-1:0]  min_off;
  logic [dhvd_pkg::LOSSW-1:0] loss;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_db   <= '0;
      right_db  <= '0;
      ovl_limit <= dhvd_pkg::OVL_LIMIT_RST;
      min_off   <= dhvd_pkg::MIN_OFF_RST;
      loss      <= dhvd_pkg::LOSS_RST;
    end else if (cfg_valid && cfg_ready) begin
      // Writes to indexes beyond the register list are dropped.
      unique case (cfg_index)
        dhvd_pkg::REG_LEFT_DB:   left_db   <= cfg_data[dhvd_pkg::DBW-1:0];
        dhvd_pkg::REG_RIGHT_DB:  right_db  <= cfg_data[dhvd_pkg::DBW-1:0];
        dhvd_pkg::REG_OVL_LIMIT: ovl_limit <= cfg_data[dhvd_pkg::OVLW-1:0];
        dhvd_pkg::REG_MIN_OFF:   min_off   <= cfg_data[dhvd_pkg::OFFW-1:0];
        dhvd_pkg::REG_LOSS:      loss      <= cfg_data[dhvd_pkg::LOSSW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Motor state.
  logic signed [MVW-1:0] stored_left;
  logic signed [MVW-1:0] stored_right;
  logic                  left_on;
  logic                  right_on;
  logic                  left_asleep;
  logic                  right_asleep;
  logic                  trip_r;
  logic                  busy;

  // Magnitude of a command with the minimum offset added; zero stays zero.
  function automatic logic [MAGW-1:0] offset_mag(input logic signed [MVW-1:0] mv,
                                                 input logic [dhvd_pkg::OFFW-1:0] off);
    logic [MAGW-1:0] a;
    a = mv[MVW-1] ? MAGW'(-mv) : MAGW'(mv);
    return (mv == '0) ? '0 : a + MAGW'(off);
  endfunction

  logic                  accept;
  logic signed [MVW-1:0] vl;
  logic signed [MVW-1:0] vr;
  logic                  stop_cmd;
  logic                  on_cmd_l;
  logic                  on_cmd_r;
  logic                  sleep_cmd;
  logic                  trip;
  logic [BATW-1:0]       batt;
  logic [DIVW-1:0]       divisor;

  assign cmd_stall = busy;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    vl        = operation ? voltage_left_mv : stored_left;
    vr        = operation ? voltage_right_mv : stored_right;
    stop_cmd  = (vl > -dhvd_pkg::STOP_MV) && (vl < dhvd_pkg::STOP_MV) &&
                (vr > -dhvd_pkg::STOP_MV) && (vr < dhvd_pkg::STOP_MV);
    // A command enables both motors unless it is a stop, which also
    // sends both to sleep. A tick keeps the flags as they are.
    on_cmd_l  = operation ? !stop_cmd : left_on;
    on_cmd_r  = operation ? !stop_cmd : right_on;
    sleep_cmd = operation && stop_cmd;
    // The overload cut-off only fires while the left motor is enabled.
    trip      = (overload_count > ovl_limit) && on_cmd_l;
    batt      = (battery_mv < dhvd_pkg::BAT_MIN_MV) ? dhvd_pkg::BAT_DEFAULT_MV : battery_mv;
    divisor   = DIVW'(batt - BATW'(loss));
  end

  // Scaling lanes, one per motor, started together so they finish together.
  logic                 lane_take;
  logic                 left_done;
  logic                 right_done;
  dhvd_pkg::lane_res_t  left_res;
  dhvd_pkg::lane_res_t  right_res;

  dhvd_lane #(.PWM_FULL(PWM_FULL)) u_left_lane (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .take     (lane_take),
    .mag      (offset_mag(vl, min_off)),
    .neg      (vl[MVW-1]),
    .divisor  (divisor),
    .deadband (left_db),
    .done     (left_done),
    .res      (left_res)
  );

  dhvd_lane #(.PWM_FULL(PWM_FULL)) u_right_lane (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .take     (lane_take),
    .mag      (offset_mag(vr, min_off)),
    .neg      (vr[MVW-1]),
    .divisor  (divisor),
    .deadband (right_db),
    .done     (right_done),
    .res      (right_res)
  );

  // The result moves to the output register once the previous one is gone.
  assign lane_take = busy && left_done && right_done && (!res_valid || !res_stall);

  // Pin mode of one bridge. An awake motor drives forward, reverse or
  // brakes on a zero value. A sleeping enabled motor with a nonzero value
  // is woken with both pins high and no duty; otherwise it stays low.
  function automatic logic [MODEW+DUTYW-1:0] pin_drive(input dhvd_pkg::lane_res_t r,
                                                      input logic on, input logic asleep);
    logic [MODEW-1:0] m;
    logic [DUTYW-1:0] d;
    m = dhvd_pkg::MODE_LOW;
    d = '0;
    if (!asleep) begin
      if (r.nz) begin
        m = r.neg ? dhvd_pkg::MODE_REV : dhvd_pkg::MODE_FWD;
        d = r.duty;
      end else begin
        m = dhvd_pkg::MODE_HIGH;
      end
    end else if (on && r.nz) begin
      m = dhvd_pkg::MODE_HIGH;
    end
    return {m, d};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_left  <= '0;
      stored_right <= '0;
      left_on      <= 1'b1;
      right_on     <= 1'b1;
      left_asleep  <= 1'b1;
      right_asleep <= 1'b1;
      busy         <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (accept) begin
        stored_left  <= vl;
        stored_right <= vr;
        left_on      <= on_cmd_l && !trip;
        right_on     <= on_cmd_r && !trip;
        left_asleep  <= left_asleep || sleep_cmd || trip;
        right_asleep <= right_asleep || sleep_cmd || trip;
        busy         <= 1'b1;
      end else if (lane_take) begin
        // A wake lasts one step; the motor is awake from the next one on.
        left_asleep  <= left_asleep && !(left_on && left_res.nz);
        right_asleep <= right_asleep && !(right_on && right_res.nz);
        busy         <= 1'b0;
      end
      if (lane_take) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trip_r <= trip;
    end
    if (lane_take) begin
      {left_mode, left_duty}   <= pin_drive(left_res, left_on, left_asleep);
      {right_mode, right_duty} <= pin_drive(right_res, right_on, right_asleep);
      left_signed_pwm          <= left_res.spwm;
      right_signed_pwm         <= right_res.spwm;
      left_enabled             <= left_on;
      right_enabled            <= right_on;
      overload_trip            <= trip_r;
    end
  end

endmodule

`default_nettype wire

### src/dhvd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dhvd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cmd_valid,
  input wire logic                          cmd_stall,
  input wire logic                          res_valid,
  input wire logic                          res_stall,
  input wire logic [dhvd_pkg::MODEW-1:0]    left_mode,
  input wire logic [dhvd_pkg::DUTYW-1:0]    left_duty,
  input wire logic [dhvd_pkg::MODEW-1:0]    right_mode,
  input wire logic                          left_enabled,
  input wire logic                          right_enabled
);

  // The block works on one command at a time.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken while another is in work");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(left_mode) && $stable(left_duty))
    else $error("stalled result changed");

  // Pins both low or both high never carry a duty.
  a_no_duty_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && (left_mode == dhvd_pkg::MODE_LOW || left_mode == dhvd_pkg::MODE_HIGH)
    |-> left_duty == '0)
    else $error("duty on an undriven bridge");

  // A disabled motor stays asleep with its pins low.
  a_disabled_low: assert property (@(posedge clk) disable iff (rst)
    res_valid && (!left_enabled || !right_enabled)
    |-> (left_enabled || left_mode == dhvd_pkg::MODE_LOW) &&
        (right_enabled || right_mode == dhvd_pkg::MODE_LOW))
    else $error("disabled motor driven");

endmodule

bind dual_hbridge_voltage_drive dhvd_checker u_dhvd_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd_valid),
  .cmd_stall     (cmd_stall),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .left_mode     (left_mode),
  .left_duty     (left_duty),
  .right_mode    (right_mode),
  .left_enabled  (left_enabled),
  .right_enabled (right_enabled)
);

`default_nettype wire
